[design/csv_record_field_parser_macros.svh]
// Assertion macros for the CSV record and field parser.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef CSV_RECORD_FIELD_PARSER_MACROS_SVH
`define CSV_RECORD_FIELD_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CSV_RFP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSV_RFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/csv_rfp_pkg.sv]
// Shared types, constants and the per-byte parse function of the CSV parser.
// No dependencies.
package csv_rfp_pkg;

  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] SEP_RESET = 8'd44;
  localparam logic [7:0] QUOTE_RESET = 8'd34;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_FIELD  = 2'd1;
  localparam logic [1:0] KIND_RECORD = 2'd2;

  // Configuration register indexes
  localparam logic CFG_SEP   = 1'b0;
  localparam logic CFG_QUOTE = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       last_of_run;
  } out_word_t;

  typedef struct packed {
    logic in_quoted;
    logic quote_seen;
    logic cr_held;
    logic at_field_start;
    logic record_open;
  } parse_st_t;

  localparam parse_st_t PARSE_RESET = '{
    in_quoted: 1'b0, quote_seen: 1'b0, cr_held: 1'b0,
    at_field_start: 1'b1, record_open: 1'b0};

  typedef struct packed {
    parse_st_t st;
    logic      emit;
    out_word_t word;
  } take_t;

  // Up to two result words produced by one input word
  typedef struct packed {
    logic [1:0] n;
    out_word_t  r0;
    out_word_t  r1;
  } step_t;

  function automatic out_word_t mk_word(logic [7:0] b, logic [1:0] kind);
    out_word_t w;
    w.out_byte    = b;
    w.out_kind    = kind;
    w.last_of_run = 1'b0;
    return w;
  endfunction

  // Handle one byte against the parse state; emits at most one word.
  function automatic take_t take_byte(parse_st_t s, logic [7:0] b,
                                      logic [7:0] sep, logic [7:0] quo);
    take_t t;
    logic  plain;
    t.st   = s;
    t.emit = 1'b0;
    t.word = mk_word(8'd0, KIND_DATA);
    plain  = 1'b1;
    if (s.in_quoted) begin
      if (s.quote_seen) begin
        t.st.quote_seen = 1'b0;
        if (b == quo) begin
          // doubled quote: one literal quote
          t.emit = 1'b1;
          t.word = mk_word(b, KIND_DATA);
          plain  = 1'b0;
        end else begin
          t.st.in_quoted = 1'b0;
        end
      end else if (b == quo) begin
        t.st.quote_seen  = 1'b1;
        t.st.record_open = 1'b1;
        plain            = 1'b0;
      end else begin
        t.emit           = 1'b1;
        t.word           = mk_word(b, KIND_DATA);
        t.st.record_open = 1'b1;
        plain            = 1'b0;
      end
    end
    if (plain) begin
      if (b == sep) begin
        t.emit              = 1'b1;
        t.word              = mk_word(8'd0, KIND_FIELD);
        t.st.at_field_start = 1'b1;
        t.st.record_open    = 1'b1;
      end else if (b == CH_LF) begin
        t.emit              = 1'b1;
        t.word              = mk_word(8'd0, KIND_RECORD);
        t.st.at_field_start = 1'b1;
        t.st.record_open    = 1'b0;
      end else if (b == quo && s.at_field_start) begin
        t.st.in_quoted      = 1'b1;
        t.st.at_field_start = 1'b0;
        t.st.record_open    = 1'b1;
      end else begin
        t.emit              = 1'b1;
        t.word              = mk_word(b, KIND_DATA);
        t.st.at_field_start = 1'b0;
        t.st.record_open    = 1'b1;
      end
    end
    return t;
  endfunction

endpackage

[design/csv_rfp_core.sv]
// Next-state and result logic for one input word of the CSV parser.
// Depends on csv_rfp_pkg.
module csv_rfp_core import csv_rfp_pkg::*; (
  input  parse_st_t  st_i,
  input  logic [7:0] sep_i,
  input  logic [7:0] quote_i,
  input  in_word_t   word_i,
  output parse_st_t  st_o,
  output step_t      step_o
);

  take_t     t_cr;
  take_t     t_b;
  parse_st_t st_mid;
  logic      cr_path;
  logic      e0;
  logic      e1;
  out_word_t w0;
  out_word_t w1;

  always_comb begin
    // A held CR is replayed unless the new word is an LF byte without end of input
    cr_path = st_i.cr_held && (word_i.end_of_input || word_i.data_byte != CH_LF);
    t_cr    = take_byte(st_i, CH_CR, sep_i, quote_i);
    st_mid  = cr_path ? t_cr.st : st_i;
    st_mid.cr_held = 1'b0;
    t_b     = take_byte(st_mid, word_i.data_byte, sep_i, quote_i);

    e0 = cr_path && t_cr.emit;
    w0 = t_cr.word;

    if (word_i.end_of_input) begin
      e1   = st_mid.record_open || st_mid.in_quoted;
      w1   = mk_word(8'd0, KIND_RECORD);
      st_o = PARSE_RESET;
    end else if (word_i.data_byte == CH_CR) begin
      e1   = 1'b0;
      w1   = t_b.word;
      st_o = st_mid;
      st_o.cr_held = 1'b1;
    end else begin
      e1   = t_b.emit;
      w1   = t_b.word;
      st_o = t_b.st;
    end

    w0.last_of_run = 1'b0;
    w1.last_of_run = 1'b1;
    step_o.n  = {1'b0, e0} + {1'b0, e1};
    step_o.r0 = e0 ? w0 : w1;
    step_o.r1 = w1;
    if (e0 && !e1) begin
      step_o.r0.last_of_run = 1'b1;
    end
  end

endmodule

[design/csv_rfp_outbuf.sv]
// Two-word result register feeding the output channel of the CSV parser.
// Depends on csv_rfp_pkg.
module csv_rfp_outbuf import csv_rfp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  step_t     step_i,
  output logic      ready_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic [1:0] cnt_q, cnt_d;
  out_word_t  slot0_q, slot0_d;
  out_word_t  slot1_q, slot1_d;
  logic       pop;

  assign pop         = (cnt_q != 2'd0) && !out_stall_i;
  // Load only when everything held leaves this cycle
  assign ready_o     = (cnt_q == 2'd0) || (cnt_q == 2'd1 && !out_stall_i);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_word_o  = slot0_q;

  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (push_i) begin
      cnt_d   = step_i.n;
      slot0_d = step_i.r0;
      slot1_d = step_i.r1;
    end else if (pop) begin
      cnt_d   = cnt_q - 2'd1;
      slot0_d = slot1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

[design/csv_record_field_parser.sv]
// CSV record and field parser: takes one raw byte per word and gives field
// bytes, end-of-field and end-of-record words. Rate: one input word per cycle
// while the output is not stalled and each word yields at most one result; a
// word that yields two (a held CR replayed ahead of a byte other than LF that
// gives a word of its own, or ahead of an end of input that closes the record)
// holds the input off until its second word is leaving. The two-word result
// register is the limit. A CR is held one word to drop CR before LF.
// Depends on csv_rfp_pkg, csv_rfp_core, csv_rfp_outbuf and the macro header.
`include "csv_record_field_parser_macros.svh"

module csv_record_field_parser import csv_rfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_word_t   in_word_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_word_t  out_word_o
);

  logic [7:0] sep_q;
  logic [7:0] quote_q;
  parse_st_t  st_q;
  parse_st_t  st_d;
  step_t      step;
  logic       ready;
  logic       in_acc;

  assign in_stall_o = !ready;
  assign in_acc     = in_valid_i && ready;

  csv_rfp_core u_core (
    .st_i    (st_q),
    .sep_i   (sep_q),
    .quote_i (quote_q),
    .word_i  (in_word_i),
    .st_o    (st_d),
    .step_o  (step)
  );

  csv_rfp_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc),
    .step_i      (step),
    .ready_o     (ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q   <= SEP_RESET;
      quote_q <= QUOTE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SEP:   sep_q   <= cfg_wdata_i;
        CFG_QUOTE: quote_q <= cfg_wdata_i;
        default:   sep_q   <= sep_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= PARSE_RESET;
    end else if (in_acc) begin
      st_q <= st_d;
    end
  end

  `CSV_RFP_ASSERT_NOW(a_mark_zero, out_valid_o && out_word_o.out_kind != KIND_DATA, out_word_o.out_byte == 8'd0, "mark word carries nonzero byte")
  `CSV_RFP_ASSERT_NOW(a_seen_in_quote, st_q.quote_seen, st_q.in_quoted, "quote pending outside quoted field")
  `CSV_RFP_ASSERT_NOW(a_quote_not_start, st_q.in_quoted, !st_q.at_field_start, "quoted field marked as field start")
  `CSV_RFP_ASSERT_NEXT(a_eoi_clears, in_acc && in_word_i.end_of_input, st_q == PARSE_RESET, "parse state not cleared after end of input")

endmodule

[bench/csv_token_checker.sv]
// Token checker for the CSV parser: watches the register, input and output ports,
// predicts the token words from each accepted byte word, and compares them in order.
// Depends on csv_rfp_pkg.
module csv_token_checker import csv_rfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  in_word_t   in_word_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  out_word_t  out_word_i,
  output int         fail_cnt_o,
  output int         pending_cnt_o,
  output int         checked_cnt_o,
  output int         record_cnt_o
);

  logic [7:0] sep_char;
  logic [7:0] quote_char;

  // Parser state as the block should hold it
  logic quoted;
  logic quote_pending;
  logic cr_pending;
  logic field_fresh;
  logic rec_open;

  out_word_t step_tokens[$];
  out_word_t expected_tokens[$];
  out_word_t exp_tok;

  int fail_cnt;
  int pending_cnt;
  int checked_cnt;
  int record_cnt;

  assign fail_cnt_o    = fail_cnt;
  assign pending_cnt_o = pending_cnt;
  assign checked_cnt_o = checked_cnt;
  assign record_cnt_o  = record_cnt;

  task automatic restart_stream();
    quoted        = 1'b0;
    quote_pending = 1'b0;
    cr_pending    = 1'b0;
    field_fresh   = 1'b1;
    rec_open      = 1'b0;
  endtask

  task automatic emit_token(input logic [7:0] b, input logic [1:0] kind);
    out_word_t t;
    t.out_byte    = b;
    t.out_kind    = kind;
    t.last_of_run = 1'b0;
    step_tokens.push_back(t);
  endtask

  task automatic absorb_char(input logic [7:0] b);
    logic as_plain;
    as_plain = 1'b1;
    if (quoted) begin
      as_plain = 1'b0;
      if (quote_pending) begin
        quote_pending = 1'b0;
        if (b == quote_char) begin
          emit_token(b, KIND_DATA);
        end else begin
          // closing quote seen: this byte falls through as unquoted
          quoted   = 1'b0;
          as_plain = 1'b1;
        end
      end else if (b == quote_char) begin
        quote_pending = 1'b1;
        rec_open      = 1'b1;
      end else begin
        emit_token(b, KIND_DATA);
        rec_open = 1'b1;
      end
    end
    if (as_plain) begin
      if (b == sep_char) begin
        emit_token(8'd0, KIND_FIELD);
        field_fresh = 1'b1;
        rec_open    = 1'b1;
      end else if (b == CH_LF) begin
        emit_token(8'd0, KIND_RECORD);
        field_fresh = 1'b1;
        rec_open    = 1'b0;
      end else if (b == quote_char && field_fresh) begin
        quoted      = 1'b1;
        field_fresh = 1'b0;
        rec_open    = 1'b1;
      end else begin
        emit_token(b, KIND_DATA);
        field_fresh = 1'b0;
        rec_open    = 1'b1;
      end
    end
  endtask

  task automatic tokenize_word(input in_word_t w);
    step_tokens.delete();
    if (w.end_of_input) begin
      if (cr_pending) begin
        cr_pending = 1'b0;
        absorb_char(CH_CR);
      end
      if (rec_open || quoted) begin
        emit_token(8'd0, KIND_RECORD);
      end
      restart_stream();
    end else begin
      // replay a held CR unless it turns out to precede LF
      if (cr_pending) begin
        cr_pending = 1'b0;
        if (w.data_byte != CH_LF) begin
          absorb_char(CH_CR);
        end
      end
      if (w.data_byte == CH_CR) begin
        cr_pending = 1'b1;
      end else begin
        absorb_char(w.data_byte);
      end
    end
    if (step_tokens.size() != 0) begin
      step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
    end
    foreach (step_tokens[k]) begin
      expected_tokens.push_back(step_tokens[k]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_char   = SEP_RESET;
      quote_char = QUOTE_RESET;
      restart_stream();
      expected_tokens.delete();
      fail_cnt    = 0;
      pending_cnt = 0;
      checked_cnt = 0;
      record_cnt  = 0;
    end else begin
      // compare before predicting so a stray word cannot match this cycle's input
      if (out_valid_i && !out_stall_i) begin
        if (expected_tokens.size() == 0) begin
          $error("result word with nothing expected: out_byte %0d out_kind %0d last_of_run %0d",
                 out_word_i.out_byte, out_word_i.out_kind, out_word_i.last_of_run);
          fail_cnt++;
        end else begin
          exp_tok = expected_tokens.pop_front();
          checked_cnt++;
          if (exp_tok.out_kind == KIND_RECORD) begin
            record_cnt++;
          end
          if (out_word_i.out_byte !== exp_tok.out_byte) begin
            $error("out_byte: expected %0d, actual %0d", exp_tok.out_byte, out_word_i.out_byte);
            fail_cnt++;
          end
          if (out_word_i.out_kind !== exp_tok.out_kind) begin
            $error("out_kind: expected %0d, actual %0d", exp_tok.out_kind, out_word_i.out_kind);
            fail_cnt++;
          end
          if (out_word_i.last_of_run !== exp_tok.last_of_run) begin
            $error("last_of_run: expected %0d, actual %0d",
                   exp_tok.last_of_run, out_word_i.last_of_run);
            fail_cnt++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SEP) begin
          sep_char = cfg_wdata_i;
        end else begin
          quote_char = cfg_wdata_i;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        tokenize_word(in_word_i);
      end
      pending_cnt = expected_tokens.size();
    end
  end

endmodule

[bench/csv_record_field_parser_tb.sv]
// Testbench top for the CSV parser: drives byte words, register writes and output
// stalls, and gives the verdict. Depends on csv_rfp_pkg, the parser and csv_token_checker.
module csv_record_field_parser_tb;
  import csv_rfp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 60;
  localparam int LATENCY     = 4;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_WORDS = 210;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_idx_i   = CFG_SEP;
  logic [7:0] cfg_wdata_i = 8'd0;
  logic       in_valid_i  = 1'b0;
  in_word_t   in_word_i   = '0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  out_word_t  out_word_o;

  int fail_cnt;
  int pending_cnt;
  int checked_cnt;
  int record_cnt;

  logic       idle_on      = 1'b1;
  logic       squeeze_req  = 1'b0;
  logic       squeeze_done = 1'b0;
  logic [7:0] cur_sep      = SEP_RESET;
  logic [7:0] cur_quo      = QUOTE_RESET;
  int         words_sent   = 0;
  int         cycle_cnt    = 0;

  // Separator and quote per phase; extremes, CR and LF roles, separator equal to quote
  logic [7:0] sep_plan [NUM_PHASES] = '{8'd44, 8'd9, 8'd0, 8'd255, 8'd13, 8'd44, 8'd10, 8'd34};
  logic [7:0] quo_plan [NUM_PHASES] = '{8'd34, 8'd39, 8'd255, 8'd0, 8'd34, 8'd13, 8'd34, 8'd34};

  csv_record_field_parser u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  csv_token_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .in_word_i     (in_word_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_word_i    (out_word_o),
    .fail_cnt_o    (fail_cnt),
    .pending_cnt_o (pending_cnt),
    .checked_cnt_o (checked_cnt),
    .record_cnt_o  (record_cnt)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Output side: random stalls, plus one long hold-off to back the parser up
  initial begin
    forever begin
      @(posedge clk_i);
      if (squeeze_req && !squeeze_done) begin
        squeeze_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_stall_i <= idle_on && ($urandom_range(0, 99) < 27);
      end
    end
  end

  // Hold valid across words when there is no gap; never lower and raise in one step
  task automatic send_word(input logic [7:0] b, input logic eoi);
    while (idle_on && $urandom_range(0, 99) < 27) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= '{data_byte: b, end_of_input: eoi};
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_word(s[i], 1'b0);
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_cnt != 0);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 5))
      0:       return cur_sep;
      1:       return cur_quo;
      2:       return CH_CR;
      3:       return CH_LF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == cur_sep || b == cur_quo || b == CH_CR || b == CH_LF);
    return b;
  endfunction

  // One record of random fields, some quoted with doubled quotes, ended by LF or CR LF
  task automatic send_record();
    int         n_fields;
    int         n_chars;
    logic [7:0] b;
    n_fields = $urandom_range(1, 4);
    for (int f = 0; f < n_fields; f++) begin
      if (f > 0) begin
        send_word(cur_sep, 1'b0);
      end
      n_chars = $urandom_range(0, 5);
      if ($urandom_range(0, 99) < 40) begin
        send_word(cur_quo, 1'b0);
        repeat (n_chars) begin
          b = ($urandom_range(0, 4) == 0) ? noise_byte() : 8'($urandom_range(0, 255));
          if (b == cur_quo) begin
            send_word(b, 1'b0);
          end
          send_word(b, 1'b0);
        end
        send_word(cur_quo, 1'b0);
      end else begin
        repeat (n_chars) send_word(plain_byte(), 1'b0);
      end
    end
    if ($urandom_range(0, 1)) begin
      send_word(CH_CR, 1'b0);
    end
    send_word(CH_LF, 1'b0);
  endtask

  initial begin
    int phase_end;
    int roll;
    int drain;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: doubled quote, byte after closing quote, mid-field quote, CR LF,
    // empty line, lone CR, byte extremes, unterminated quote, bare and CR-held end
    send_text("\"a\"\"b\"x,y\"z\015\012\012\015q");
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b1);
    send_text("\"u");
    send_word(8'hFF, 1'b1);
    send_word(8'h5A, 1'b1);
    send_word(CH_CR, 1'b0);
    send_word(8'hA5, 1'b1);
    settle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      cur_sep = sep_plan[p];
      cur_quo = quo_plan[p];
      write_reg(CFG_SEP, cur_sep);
      write_reg(CFG_QUOTE, cur_quo);
      // run one phase without any idling; back the output up in another
      idle_on     <= (p != 1);
      squeeze_req <= (p == 3);
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
          send_record();
        end else if (roll < 97) begin
          repeat ($urandom_range(1, 4)) send_word(noise_byte(), 1'b0);
        end else begin
          send_word(8'($urandom_range(0, 255)), 1'b1);
        end
      end
      send_word(8'($urandom_range(0, 255)), 1'b1);
      settle();
    end

    in_valid_i <= 1'b0;
    drain = 0;
    while (pending_cnt != 0 && drain < 5000) begin
      @(negedge clk_i);
      drain++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_cnt != 0) begin
      $error("%0d result words never arrived", pending_cnt);
    end

    $display("Run covered %0d byte words over %0d separator/quote settings,", words_sent,
             NUM_PHASES + 1);
    $display("with %0d result words checked and %0d records closed.", checked_cnt, record_cnt);
    if (fail_cnt == 0 && pending_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[csv_record_field_parser.f]
+incdir+design
design/csv_rfp_pkg.sv
design/csv_rfp_core.sv
design/csv_rfp_outbuf.sv
design/csv_record_field_parser.sv
bench/csv_token_checker.sv
bench/csv_record_field_parser_tb.sv
